// ===== src/dlae_pkg.sv =====
// ----------------------------------------------------------------------------
// dlae_pkg: shared types and constants of the dual looping ADSR envelope
// Level and time formats, stored state entry layout, register indexes and
// segment codes.
// ----------------------------------------------------------------------------
package dlae_pkg;

	localparam int LVL_W      = 17;   // Q1.16 level, 65536 = 1.0
	localparam int TIME_W     = 26;   // Q2.24 seconds, elapsed time
	localparam int DUR_W      = 25;   // Q1.24 seconds, segment duration
	localparam int SP_W       = 24;   // Q0.24 seconds per tick
	localparam int VOICE_W    = 4;
	localparam int GATE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int QUOT_W     = 17;   // quotient bits kept before saturation
	localparam int PROD_W     = SP_W + LVL_W;

	localparam logic [LVL_W-1:0]  LEVEL_ONE = 17'h10000;
	localparam logic [TIME_W-1:0] TIME_MAX  = 26'h3FFFFFF;
	localparam logic [SP_W-1:0]   SP_RESET  = 24'd349;

	localparam logic [GATE_W-1:0] GATE_LOW  = 2'd0;
	localparam logic [GATE_W-1:0] GATE_HIGH = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE_A   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE_B   = 2'd2;

	localparam logic [1:0] SEG_ATTACK  = 2'd0;
	localparam logic [1:0] SEG_DECAY   = 2'd1;
	localparam logic [1:0] SEG_SUSTAIN = 2'd2;
	localparam logic [1:0] SEG_RELEASE = 2'd3;

	// state of one envelope of one voice
	typedef struct packed {
		logic              rearm;
		logic [LVL_W-1:0]  start;
		logic [TIME_W-1:0] t;
		logic [LVL_W-1:0]  lvl;
	} ent_t;

endpackage

// ===== src/dual_looping_adsr_envelope.sv =====
// An item for a voice outside VOICE_COUNT skips the envelope steps and goes
// straight to the output state.
// Throughput: one item at a time; each envelope runs a 17-step restoring
// divider on one shared subtractor, skipped when the step is zero or saturates.
// Reset: arst_n clears the sequencer, the registers (sample_period to 349)
// and the per-entry valid bits, so all envelope state reads as zero.
// ----------------------------------------------------------------------------
// dual_looping_adsr_envelope
// Two linear ADSR envelopes per voice sharing one gate, with optional loop
// mode; state kept in a small memory, one shared divider step per cycle.
// ----------------------------------------------------------------------------
module dual_looping_adsr_envelope #(
	parameter int VOICE_COUNT = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [dlae_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dlae_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// voice, gate_level, attack_time_a, decay_time_a, sustain_level_a,
	// release_time_a, attack_time_b, decay_time_b, sustain_level_b,
	// release_time_b, zero pad
	input  logic [191:0]                     s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// out_voice, level_a, level_b, zero pad
	output logic [39:0]                      m_axis_tdata
);
	import dlae_pkg::*;

	localparam int ENTRIES = VOICE_COUNT * 2;
	localparam int AW      = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
	localparam int DEPTH   = 2 ** AW;
	localparam logic [6:0] VC = 7'(VOICE_COUNT);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_SEG  = 4'd2;
	localparam logic [3:0] S_MUL  = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_DIV  = 4'd5;
	localparam logic [3:0] S_UPD  = 4'd6;
	localparam logic [3:0] S_OUT  = 4'd7;

	// configuration
	logic [SP_W-1:0] sp_q;
	logic            loop_a_q, loop_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= SP_RESET;
			loop_a_q <= 1'b0;
			loop_b_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_PERIOD: sp_q     <= cfg_wdata[SP_W-1:0];
				REG_LOOP_MODE_A:   loop_a_q <= cfg_wdata[0];
				REG_LOOP_MODE_B:   loop_b_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input unpacking
	logic [VOICE_W-1:0] in_voice;
	logic [GATE_W-1:0]  in_gate;
	logic [DUR_W-1:0]   in_att_a, in_dec_a, in_rel_a, in_att_b, in_dec_b, in_rel_b;
	logic [LVL_W-1:0]   in_sus_a, in_sus_b;

	assign in_voice = s_axis_tdata[3:0];
	assign in_gate  = s_axis_tdata[5:4];
	assign in_att_a = s_axis_tdata[30:6];
	assign in_dec_a = s_axis_tdata[55:31];
	assign in_sus_a = s_axis_tdata[72:56];
	assign in_rel_a = s_axis_tdata[97:73];
	assign in_att_b = s_axis_tdata[122:98];
	assign in_dec_b = s_axis_tdata[147:123];
	assign in_sus_b = s_axis_tdata[164:148];
	assign in_rel_b = s_axis_tdata[189:165];

	// sequencer and item registers
	logic [3:0]         state_q;
	logic               e_q;
	logic [VOICE_W-1:0] voice_q;
	logic               high_q, low_q;
	logic [DUR_W-1:0]   att_a_q, dec_a_q, rel_a_q, att_b_q, dec_b_q, rel_b_q;
	logic [LVL_W-1:0]   sus_a_q, sus_b_q;
	logic [LVL_W-1:0]   lvl_a_q, lvl_b_q;
	logic               in_range;
	logic               in_xfer;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign in_range      = {3'b000, in_voice} < VC;

	// active envelope settings
	logic [DUR_W-1:0] att_e, dec_e, rel_e;
	logic [LVL_W-1:0] sus_e;
	logic             loop_e;

	assign att_e  = e_q ? att_b_q : att_a_q;
	assign dec_e  = e_q ? dec_b_q : dec_a_q;
	assign rel_e  = e_q ? rel_b_q : rel_a_q;
	assign sus_e  = e_q ? sus_b_q : sus_a_q;
	assign loop_e = e_q ? loop_b_q : loop_a_q;

	// state memory with per-entry valid bits
	ent_t             mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	ent_t             rd_q;
	logic             rd_vld_q;
	logic [AW-1:0]    addr;
	logic             mem_we;
	ent_t             wr_ent;

	assign addr   = AW'({voice_q, e_q});
	assign mem_we = (state_q == S_UPD);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr] <= wr_ent;
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (mem_we) begin
				vld_q[addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[addr];
		end
	end

	// segment selection on the fetched entry
	ent_t              cur;
	logic              trig;
	logic [TIME_W-1:0] t0;
	logic [LVL_W-1:0]  start0;
	logic              rearm0;
	logic [TIME_W-1:0] ad;
	logic [1:0]        seg0;
	logic [LVL_W-1:0]  span0;
	logic [DUR_W-1:0]  dur0;

	always_comb begin
		cur    = rd_vld_q ? rd_q : '0;
		trig   = high_q && cur.rearm;
		t0     = trig ? '0 : cur.t;
		start0 = trig ? cur.lvl : cur.start;
		rearm0 = high_q ? 1'b0 : (low_q ? 1'b1 : cur.rearm);
		ad     = {1'b0, att_e} + {1'b0, dec_e};
		if (!high_q) begin
			seg0 = SEG_RELEASE;
		end else if (t0 <= {1'b0, att_e}) begin
			seg0 = SEG_ATTACK;
		end else if (t0 <= ad) begin
			seg0 = SEG_DECAY;
		end else begin
			seg0 = loop_e ? SEG_RELEASE : SEG_SUSTAIN;
		end
		case (seg0)
			SEG_ATTACK: begin
				span0 = LEVEL_ONE - start0;
				dur0  = att_e;
			end
			SEG_DECAY: begin
				span0 = LEVEL_ONE - sus_e;
				dur0  = dec_e;
			end
			SEG_RELEASE: begin
				span0 = cur.lvl;
				dur0  = rel_e;
			end
			default: begin
				span0 = '0;
				dur0  = '0;
			end
		endcase
	end

	logic [1:0]        seg_q;
	logic [TIME_W-1:0] t_q;
	logic [LVL_W-1:0]  start_q, lvl_q, span_q;
	logic              rearm_q;
	logic [DUR_W-1:0]  dur_q;
	logic [PROD_W-1:0] p_q;
	logic [DUR_W-1:0]  rem_q;
	logic [QUOT_W-1:0] lo_q, quot_q;
	logic [4:0]        cnt_q;
	logic              sat_q, zero_q;

	// shared divider step
	logic [DUR_W:0]   trial;
	logic             ge;
	logic [DUR_W-1:0] rem_nxt;
	logic             p_ovf;

	assign trial   = {rem_q, lo_q[QUOT_W-1]};
	assign ge      = trial >= {1'b0, dur_q};
	assign rem_nxt = ge ? DUR_W'(trial - {1'b0, dur_q}) : trial[DUR_W-1:0];
	assign p_ovf   = {1'b0, p_q[PROD_W-1:QUOT_W]} >= dur_q;

	// level and elapsed-time update
	logic [QUOT_W:0]   mag;
	logic [QUOT_W+1:0] up_sum;
	logic [LVL_W-1:0]  lvl_n;
	logic [TIME_W:0]   adr, tsum, tn;
	logic [TIME_W-1:0] t_n;
	logic              down;

	always_comb begin
		down = (seg_q != SEG_ATTACK);
		if (zero_q) begin
			mag = '0;
		end else if (sat_q) begin
			mag = 18'h20000;
		end else begin
			mag = {1'b0, quot_q} + {17'd0, down && (rem_q != '0)};
		end
		up_sum = {2'b00, lvl_q} + {1'b0, mag};
		case (seg_q)
			SEG_ATTACK:  lvl_n = (up_sum > {2'b00, LEVEL_ONE}) ? LEVEL_ONE : up_sum[LVL_W-1:0];
			SEG_SUSTAIN: lvl_n = sus_e;
			default:     lvl_n = ({1'b0, lvl_q} >= mag) ? LVL_W'({1'b0, lvl_q} - mag) : '0;
		endcase

		adr  = {2'b00, att_e} + {2'b00, dec_e} + {2'b00, rel_e};
		tsum = {1'b0, t_q} + {3'b000, sp_q};
		if (!loop_e) begin
			tn = (seg_q != SEG_SUSTAIN) ? tsum : {1'b0, t_q};
		end else if (({1'b0, t_q} >= adr) && !high_q) begin
			tn = '0;
		end else begin
			tn = (tsum >= adr) ? '0 : tsum;
		end
		t_n = (tn > {1'b0, TIME_MAX}) ? TIME_MAX : tn[TIME_W-1:0];

		wr_ent.rearm = rearm_q;
		wr_ent.start = start_q;
		wr_ent.t     = t_n;
		wr_ent.lvl   = lvl_n;
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			voice_q <= in_voice;
			high_q  <= (in_gate == GATE_HIGH);
			low_q   <= (in_gate == GATE_LOW);
			att_a_q <= in_att_a;
			dec_a_q <= in_dec_a;
			rel_a_q <= in_rel_a;
			att_b_q <= in_att_b;
			dec_b_q <= in_dec_b;
			rel_b_q <= in_rel_b;
			sus_a_q <= (in_sus_a > LEVEL_ONE) ? LEVEL_ONE : in_sus_a;
			sus_b_q <= (in_sus_b > LEVEL_ONE) ? LEVEL_ONE : in_sus_b;
			lvl_a_q <= '0;
			lvl_b_q <= '0;
		end
		case (state_q)
			S_SEG: begin
				seg_q   <= seg0;
				t_q     <= t0;
				start_q <= start0;
				rearm_q <= rearm0;
				lvl_q   <= cur.lvl;
				span_q  <= span0;
				dur_q   <= dur0;
			end
			S_MUL: begin
				p_q <= span_q * sp_q;
			end
			S_CHK: begin
				zero_q <= (span_q == '0);
				sat_q  <= (dur_q == '0) || p_ovf;
				rem_q  <= {1'b0, p_q[PROD_W-1:QUOT_W]};
				lo_q   <= p_q[QUOT_W-1:0];
				quot_q <= '0;
			end
			S_DIV: begin
				rem_q  <= rem_nxt;
				lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], ge};
			end
			S_UPD: begin
				if (e_q) begin
					lvl_b_q <= lvl_n;
				end else begin
					lvl_a_q <= lvl_n;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			e_q     <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						e_q     <= 1'b0;
						state_q <= in_range ? S_RD : S_OUT;
					end
				end
				S_RD:  state_q <= S_SEG;
				S_SEG: state_q <= S_MUL;
				S_MUL: state_q <= S_CHK;
				S_CHK: begin
					cnt_q <= '0;
					if ((span_q == '0) || (dur_q == '0) || p_ovf) begin
						state_q <= S_UPD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QUOT_W - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!e_q) begin
						e_q     <= 1'b1;
						state_q <= S_RD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	logic out_load;

	assign out_load = (state_q == S_OUT) && (!m_axis_tvalid || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (out_load) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {2'b00, lvl_b_q, lvl_a_q, voice_q};
		end
	end

	// checks
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[20:4] <= LEVEL_ONE) && (m_axis_tdata[37:21] <= LEVEL_ONE))
		else $error("envelope level above one");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ({3'b000, voice_q} < VC))
		else $error("state write for a voice out of range");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q < 5'(QUOT_W)))
		else $error("divider ran past its step count");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("new transfer taken while an item is in work");

endmodule

// ===== tb/sv/dual_looping_adsr_envelope_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_looping_adsr_envelope_tb
// Streams sample ticks into the envelope block and checks the returned levels
// against a cycle-free predictor. It uses directed ticks first, then per-voice
// gate sequences with random segment settings, over several register settings
// and with random stalls on both streams.
// ----------------------------------------------------------------------------
module dual_looping_adsr_envelope_tb;
	import dlae_pkg::*;

	localparam int VOICE_COUNT = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [GATE_W-1:0] GATE_MID = 2'd1;
	localparam logic [GATE_W-1:0] GATE_ODD = 2'd3;
	localparam logic [DUR_W-1:0]  DUR_MAX  = 25'h1FFFFFF;
	localparam logic [DUR_W-1:0]  DUR_ONE  = 25'h1000000;
	localparam logic [LVL_W-1:0]  SUS_MAX  = 17'h1FFFF;

	typedef struct {
		logic [VOICE_W-1:0] voice;
		logic [GATE_W-1:0]  gate;
		logic [DUR_W-1:0]   att_a, dec_a, rel_a, att_b, dec_b, rel_b;
		logic [LVL_W-1:0]   sus_a, sus_b;
	} tick_t;

	typedef struct {
		logic [VOICE_W-1:0] voice;
		logic [LVL_W-1:0]   lvl_a, lvl_b;
	} levels_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [191:0]          s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [39:0]           m_axis_tdata;

	dual_looping_adsr_envelope #(.VOICE_COUNT(VOICE_COUNT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// register mirror and per-voice envelope state of the predictor
	logic [SP_W-1:0]   period_q = SP_RESET;
	logic              loop_a_q = 1'b0;
	logic              loop_b_q = 1'b0;
	logic [LVL_W-1:0]  env_lvl   [VOICE_COUNT][2];
	logic [TIME_W-1:0] env_time  [VOICE_COUNT][2];
	logic [LVL_W-1:0]  env_start [VOICE_COUNT][2];
	logic              env_rearm [VOICE_COUNT][2];

	tick_t   tick_queue[$];
	tick_t   cur_tick;
	levels_t level_expect[$];

	int send_idle_pct = 25;
	int recv_idle_pct = 67;
	int mismatch_count = 0;
	int levels_checked = 0;
	int ticks_sent = 0;
	int reg_writes = 0;
	int cycle_count = 0;

	// stimulus shaping: per-voice gate runs and segment settings
	int          gate_left   [VOICE_COUNT];
	logic [1:0]  gate_now    [VOICE_COUNT];
	tick_t       voice_setup [VOICE_COUNT];
	int          focus_base;

	initial forever #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d levels pending", cycle_count,
				level_expect.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic longint seg_step(longint sp, longint span, longint dur, bit down);
		if (span == 0)
			return 0;
		if (dur == 0)
			return down ? -2 * longint'(LEVEL_ONE) : 2 * longint'(LEVEL_ONE);
		if (down)
			return -((sp * span + dur - 1) / dur);
		return (sp * span) / dur;
	endfunction

	function automatic logic [LVL_W-1:0] advance_envelope(int v, int e, bit high, bit low,
		bit loop, longint att, longint dec, longint sus, longint rel);
		longint     sp, t, lvl, adr, one;
		logic [1:0] seg;
		sp = longint'(period_q);
		one = longint'(LEVEL_ONE);
		adr = att + dec + rel;
		if (high && env_rearm[v][e]) begin
			env_time[v][e] = '0;
			env_start[v][e] = env_lvl[v][e];
		end
		if (high)
			env_rearm[v][e] = 1'b0;
		if (low)
			env_rearm[v][e] = 1'b1;

		t = longint'(env_time[v][e]);
		if (!high)
			seg = SEG_RELEASE;
		else if (t <= att)
			seg = SEG_ATTACK;
		else if (t <= att + dec)
			seg = SEG_DECAY;
		else
			seg = loop ? SEG_RELEASE : SEG_SUSTAIN;

		lvl = longint'(env_lvl[v][e]);
		case (seg)
			SEG_ATTACK:  lvl += seg_step(sp, one - longint'(env_start[v][e]), att, 1'b0);
			SEG_DECAY:   lvl += seg_step(sp, one - sus, dec, 1'b1);
			SEG_RELEASE: lvl += seg_step(sp, lvl, rel, 1'b1);
			default:     lvl = sus;
		endcase
		if (lvl < 0)
			lvl = 0;
		if (lvl > one)
			lvl = one;
		env_lvl[v][e] = lvl[LVL_W-1:0];

		if (!loop) begin
			if (seg != SEG_SUSTAIN)
				t += sp;
		end else if (t >= adr && !high) begin
			t = 0;
		end else begin
			t += sp;
			if (t >= adr)
				t = 0;
		end
		if (t > longint'(TIME_MAX))
			t = longint'(TIME_MAX);
		env_time[v][e] = t[TIME_W-1:0];
		return env_lvl[v][e];
	endfunction

	function automatic void predict_levels(tick_t x);
		levels_t r;
		longint  sa, sb;
		bit      high, low;
		high = (x.gate == GATE_HIGH);
		low = (x.gate == GATE_LOW);
		sa = (x.sus_a > LEVEL_ONE) ? longint'(LEVEL_ONE) : longint'(x.sus_a);
		sb = (x.sus_b > LEVEL_ONE) ? longint'(LEVEL_ONE) : longint'(x.sus_b);
		r.voice = x.voice;
		r.lvl_a = '0;
		r.lvl_b = '0;
		if (int'(x.voice) < VOICE_COUNT) begin
			r.lvl_a = advance_envelope(int'(x.voice), 0, high, low, loop_a_q,
				x.att_a, x.dec_a, sa, x.rel_a);
			r.lvl_b = advance_envelope(int'(x.voice), 1, high, low, loop_b_q,
				x.att_b, x.dec_b, sb, x.rel_b);
		end
		level_expect.push_back(r);
	endfunction

	function automatic logic [191:0] pack_tick(tick_t x);
		return {2'b00, x.rel_b, x.sus_b, x.dec_b, x.att_b,
			x.rel_a, x.sus_a, x.dec_a, x.att_a, x.gate, x.voice};
	endfunction

	// sender: new tick offered whenever the slot is free, with random idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_levels(cur_tick);
				ticks_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_tick = tick_queue.pop_front();
					s_axis_tdata <= pack_tick(cur_tick);
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random backpressure, compare each transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		levels_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				levels_checked++;
				if (level_expect.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: data %h", m_axis_tdata);
				end else begin
					want = level_expect.pop_front();
					if (m_axis_tdata[3:0] !== want.voice || m_axis_tdata[20:4] !== want.lvl_a ||
						m_axis_tdata[37:21] !== want.lvl_b) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: voice %0d/%0d level_a %0d/%0d level_b %0d/%0d (exp/act)",
								want.voice, m_axis_tdata[3:0], want.lvl_a, m_axis_tdata[20:4],
								want.lvl_b, m_axis_tdata[37:21]);
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SAMPLE_PERIOD: period_q = val;
			REG_LOOP_MODE_A:   loop_a_q = val[0];
			REG_LOOP_MODE_B:   loop_b_q = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic wait_drained();
		while (tick_queue.size() != 0 || s_axis_tvalid || level_expect.size() != 0)
			@(posedge clk);
	endtask

	function automatic tick_t make_tick(int v, logic [GATE_W-1:0] g,
		logic [DUR_W-1:0] aa, logic [DUR_W-1:0] da, logic [LVL_W-1:0] sa, logic [DUR_W-1:0] ra,
		logic [DUR_W-1:0] ab, logic [DUR_W-1:0] db, logic [LVL_W-1:0] sb, logic [DUR_W-1:0] rb);
		tick_t x;
		x.voice = v[VOICE_W-1:0];
		x.gate = g;
		x.att_a = aa; x.dec_a = da; x.sus_a = sa; x.rel_a = ra;
		x.att_b = ab; x.dec_b = db; x.sus_b = sb; x.rel_b = rb;
		return x;
	endfunction

	// durations are mostly a few ticks long so segments actually finish
	function automatic logic [DUR_W-1:0] pick_duration();
		longint k;
		int     r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return DUR_W'($urandom_range(0, 33554431));
		if (r < 20)
			return DUR_ONE;
		if (period_q == 0)
			return DUR_W'($urandom_range(1, 5000));
		k = longint'(period_q) * $urandom_range(1, 10) + $urandom_range(0, period_q);
		if (k > longint'(DUR_MAX))
			k = longint'(DUR_MAX);
		return k[DUR_W-1:0];
	endfunction

	function automatic logic [LVL_W-1:0] pick_sustain();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return LEVEL_ONE;
		if (r < 30)
			return LVL_W'($urandom_range(65537, 131071));
		return LVL_W'($urandom_range(0, 65536));
	endfunction

	function automatic tick_t fresh_setup();
		return make_tick(0, GATE_LOW, pick_duration(), pick_duration(), pick_sustain(),
			pick_duration(), pick_duration(), pick_duration(), pick_sustain(), pick_duration());
	endfunction

	function automatic tick_t noise_tick();
		return make_tick($urandom_range(VOICE_COUNT - 1), GATE_W'($urandom_range(3)),
			DUR_W'($urandom_range(0, 33554431)), DUR_W'($urandom_range(0, 33554431)),
			LVL_W'($urandom_range(0, 131071)),
			DUR_W'($urandom_range(0, 33554431)), DUR_W'($urandom_range(0, 33554431)),
			DUR_W'($urandom_range(0, 33554431)),
			LVL_W'($urandom_range(0, 131071)), DUR_W'($urandom_range(0, 33554431)));
	endfunction

	// mostly gate high/low runs on a few busy voices, some broken runs and noise
	task automatic queue_random_ticks(int count);
		int    v;
		tick_t x;
		focus_base = $urandom_range(VOICE_COUNT - 4);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 12) begin
				x = noise_tick();
			end else begin
				v = ($urandom_range(99) < 70) ? focus_base + $urandom_range(3)
					: $urandom_range(VOICE_COUNT - 1);
				if (gate_left[v] == 0) begin
					if (gate_now[v] == GATE_HIGH) begin
						if ($urandom_range(9) < 8)
							gate_now[v] = GATE_LOW;
						else
							gate_now[v] = $urandom_range(1) ? GATE_MID : GATE_ODD;
						gate_left[v] = $urandom_range(1, 6);
					end else begin
						gate_now[v] = GATE_HIGH;
						gate_left[v] = $urandom_range(2, 20);
						if ($urandom_range(2) == 0)
							voice_setup[v] = fresh_setup();
					end
				end
				gate_left[v]--;
				x = voice_setup[v];
				x.voice = v[VOICE_W-1:0];
				x.gate = gate_now[v];
			end
			tick_queue.push_back(x);
		end
	endtask

	task automatic run_phase(logic [SP_W-1:0] sp, logic la, logic lb, int send_pct,
		int recv_pct, int count);
		write_reg(REG_SAMPLE_PERIOD, sp);
		write_reg(REG_LOOP_MODE_A, CFG_DATA_W'(la));
		write_reg(REG_LOOP_MODE_B, CFG_DATA_W'(lb));
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int v = 0; v < VOICE_COUNT; v++)
			voice_setup[v] = fresh_setup();
		queue_random_ticks(count);
		wait_drained();
	endtask

	initial begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			for (int e = 0; e < 2; e++) begin
				env_lvl[v][e] = '0;
				env_time[v][e] = '0;
				env_start[v][e] = '0;
				env_rearm[v][e] = 1'b0;
			end
			gate_left[v] = 0;
			gate_now[v] = GATE_LOW;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// zero durations jump at once; sustain above one saturates
		tick_queue.push_back(make_tick(0, GATE_HIGH, 0, 0, SUS_MAX, 0, 0, 0, 0, 0));
		tick_queue.push_back(make_tick(0, GATE_HIGH, 0, 0, SUS_MAX, 0, 0, 0, 0, 0));
		tick_queue.push_back(make_tick(0, GATE_ODD, 0, 0, SUS_MAX, 0, 0, 0, 0, 0));
		tick_queue.push_back(make_tick(0, GATE_LOW, 0, 0, SUS_MAX, 0, 0, 0, 0, 0));
		// short A segments, B at one second
		for (int i = 0; i < 5; i++)
			tick_queue.push_back(make_tick(0, GATE_HIGH, 1048, 698, 32768, 1396,
				DUR_ONE, DUR_ONE, LEVEL_ONE, DUR_ONE));
		tick_queue.push_back(make_tick(0, GATE_MID, 1048, 698, 32768, 1396,
			DUR_ONE, DUR_ONE, LEVEL_ONE, DUR_ONE));
		tick_queue.push_back(make_tick(0, GATE_MID, 1048, 698, 32768, 1396,
			DUR_ONE, DUR_ONE, LEVEL_ONE, DUR_ONE));
		// gate back high without a low in between: no retrigger
		tick_queue.push_back(make_tick(0, GATE_HIGH, 1048, 698, 32768, 1396,
			DUR_ONE, DUR_ONE, LEVEL_ONE, DUR_ONE));
		tick_queue.push_back(make_tick(15, GATE_HIGH, DUR_MAX, DUR_MAX, 65535, DUR_MAX,
			1, 1, 1, 1));
		tick_queue.push_back(make_tick(15, GATE_LOW, DUR_MAX, DUR_MAX, 65535, DUR_MAX,
			1, 1, 1, 1));
		tick_queue.push_back(make_tick(15, GATE_HIGH, DUR_MAX, DUR_MAX, 65535, DUR_MAX,
			1, 1, 1, 1));
		tick_queue.push_back(make_tick(7, GATE_LOW, 0, 0, 0, 0, 0, 0, 0, 0));
		tick_queue.push_back(make_tick(7, GATE_HIGH, 0, 349, 0, 0, 349, 0, 65536, 0));
		tick_queue.push_back(make_tick(7, GATE_HIGH, 0, 349, 0, 0, 349, 0, 65536, 0));
		tick_queue.push_back(make_tick(7, GATE_HIGH, 0, 349, 0, 0, 349, 0, 65536, 0));
		tick_queue.push_back(make_tick(7, GATE_ODD, 0, 349, 0, 700, 349, 0, 65536, 0));
		tick_queue.push_back(make_tick(7, GATE_ODD, 0, 349, 0, 700, 349, 0, 65536, 0));
		wait_drained();

		run_phase(SP_RESET, 1'b0, 1'b0, 25, 67, 150);
		run_phase(24'hFFFFFF, 1'b1, 1'b0, 25, 67, 100);
		run_phase(24'd1, 1'b0, 1'b1, 67, 25, 100);
		run_phase(SP_W'($urandom_range(200, 4000)), 1'b1, 1'b1, 67, 25, 150);
		// zero period: only sustain and zero-duration jumps move the levels
		run_phase('0, 1'b1, 1'b1, 0, 0, 50);
		run_phase(SP_W'($urandom_range(1, 16777215)), 1'b1, 1'b0, 0, 0, 120);
		run_phase(SP_RESET, 1'b0, 1'b0, 0, 0, 80);

		repeat (60) @(posedge clk);
		$display("%0d ticks sent, %0d level results checked, %0d register writes",
			ticks_sent, levels_checked, reg_writes);
		$display("periods 0, 1, 349, max and random; hold and loop modes on both envelopes");
		if (mismatch_count == 0 && level_expect.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d levels never arrived", mismatch_count,
				level_expect.size());
			$display("status: fail");
		end
		$finish;
	end

endmodule
